### src/tah_pkg.sv
// ----------------------------------------------------------------------------
// tah_pkg - shared types and constants for the tilt and heading block
// Pipeline control, payload structs, stage counts and the CORDIC angle table.
// ----------------------------------------------------------------------------
package tah_pkg;

  // default angle resolution: 2^-7 degree
  localparam int ANGLE_FRAC_BITS_DEF = 7;

  // stage counts of the arithmetic units
  localparam int SQRT_STEPS   = 32;
  localparam int NORM_STEPS   = 6;
  localparam int CORDIC_STEPS = 28;

  // per-stage control handed to each pipeline unit
  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

  // one raw sensor frame
  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] mx;
    logic signed [15:0] my;
  } raw_t;

  // one finished result
  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic        [15:0] heading;
  } res_t;

  // atan(2^-i) in degrees, Q24
  function automatic logic [31:0] atan_q24(input int idx);
    logic [31:0] v;
    unique case (idx)
      0:       v = 32'd754974720;
      1:       v = 32'd445687602;
      2:       v = 32'd235489089;
      3:       v = 32'd119537938;
      4:       v = 32'd60000934;
      5:       v = 32'd30029717;
      6:       v = 32'd15018523;
      7:       v = 32'd7509720;
      8:       v = 32'd3754917;
      9:       v = 32'd1877466;
      10:      v = 32'd938734;
      11:      v = 32'd469367;
      12:      v = 32'd234684;
      13:      v = 32'd117342;
      14:      v = 32'd58671;
      15:      v = 32'd29335;
      16:      v = 32'd14668;
      17:      v = 32'd7334;
      18:      v = 32'd3667;
      19:      v = 32'd1833;
      20:      v = 32'd917;
      21:      v = 32'd458;
      22:      v = 32'd229;
      23:      v = 32'd115;
      24:      v = 32'd57;
      25:      v = 32'd29;
      26:      v = 32'd14;
      27:      v = 32'd7;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

### src/tah_if.sv
// ----------------------------------------------------------------------------
// tah_if - request channels of the tilt and heading block
// Valid/ready channels for sensor frames in and angle results out.
// ----------------------------------------------------------------------------
interface tah_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] mag_x;
  logic signed [15:0] mag_y;

  modport source (output valid, accel_x, accel_y, accel_z, mag_x, mag_y, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, mag_x, mag_y, output ready);
endinterface

interface tah_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic        [15:0] heading_angle;

  modport source (output valid, roll_angle, pitch_angle, heading_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, heading_angle, output ready);
endinterface

### src/tah_isqrt.sv
// ----------------------------------------------------------------------------
// tah_isqrt - pipelined integer square root
// floor(sqrt(s * 2^32)), one result bit per stage, restoring digit recurrence.
// ----------------------------------------------------------------------------
module tah_isqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  tah_pkg::pipe_ctl_t  ctl,
  input  logic [31:0]         s,
  output logic                out_vld,
  output logic [31:0]         root
);

  localparam int SQ = tah_pkg::SQRT_STEPS;

  logic        v_r  [1:SQ];
  logic [31:0] s_r  [1:SQ];
  logic [31:0] rt_r [1:SQ];
  logic [34:0] rm_r [1:SQ];

  logic        v_in  [SQ];
  logic [31:0] s_in  [SQ];
  logic [31:0] rt_in [SQ];
  logic [34:0] rm_in [SQ];

  for (genvar i = 0; i < SQ; i++) begin : g_stage
    logic [1:0]  pair;
    logic [34:0] rem2;
    logic [34:0] trial;
    logic        ge;

    // stage inputs: operand enters at stage zero
    if (i == 0) begin : g_first
      assign v_in[i]  = ctl.vld;
      assign s_in[i]  = s;
      assign rt_in[i] = '0;
      assign rm_in[i] = '0;
    end else begin : g_next
      assign v_in[i]  = v_r[i];
      assign s_in[i]  = s_r[i];
      assign rt_in[i] = rt_r[i];
      assign rm_in[i] = rm_r[i];
    end

    // next two radicand bits; the low half of the radicand is zero
    if (i < 16) begin : g_pair
      assign pair = s_in[i][31-2*i -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    // one root bit
    assign rem2  = {rm_in[i][32:0], pair};
    assign trial = {1'b0, rt_in[i], 2'b01};
    assign ge    = (rem2 >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (ctl.en) begin
        v_r[i+1] <= v_in[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        s_r[i+1]  <= s_in[i];
        rt_r[i+1] <= {rt_in[i][30:0], ge};
        rm_r[i+1] <= ge ? (rem2 - trial) : rem2;
      end
    end
  end

  assign out_vld = v_r[SQ];
  assign root    = rt_r[SQ];

endmodule

### src/tah_atan2.sv
// ----------------------------------------------------------------------------
// tah_atan2 - pipelined four-quadrant arctangent
// Normalize, 28 CORDIC vectoring stages in Q24 degrees, clamp, round, restore
// the quadrant. Result in 2^-FRAC degree, range -180 to +180.
// ----------------------------------------------------------------------------
module tah_atan2 #(
  parameter  int FRAC = tah_pkg::ANGLE_FRAC_BITS_DEF,
  localparam int RW   = FRAC + 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tah_pkg::pipe_ctl_t    ctl,
  input  logic [31:0]           ux,
  input  logic [31:0]           uy,
  input  logic                  x_neg,
  input  logic                  y_neg,
  output logic                  out_vld,
  output logic signed [RW-1:0]  angle
);

  localparam int NW  = 53;
  localparam int CW  = 57;
  localparam int ZW  = 34;
  localparam int NRM = tah_pkg::NORM_STEPS;
  localparam int STP = tah_pkg::CORDIC_STEPS;
  localparam int SH  = 24 - FRAC;
  localparam int AW  = FRAC + 8;
  localparam logic [30:0] Z90  = 31'(90 * (2 ** 24));
  localparam logic [31:0] HALF = 32'(2 ** (SH - 1));
  localparam logic [RW-1:0] A180 = RW'(180 * (2 ** FRAC));

  typedef struct packed {
    logic xz;
    logic yz;
    logic xn;
    logic yn;
  } flg_t;

  // ---------------- entry stage ----------------
  logic          ev_r;
  logic [NW-1:0] ex_r, ey_r, em_r;
  flg_t          ef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r <= 1'b0;
    end else if (ctl.en) begin
      ev_r <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      ex_r    <= {21'b0, ux};
      ey_r    <= {21'b0, uy};
      em_r    <= (ux > uy) ? {21'b0, ux} : {21'b0, uy};
      ef_r.xz <= (ux == '0);
      ef_r.yz <= (uy == '0);
      ef_r.xn <= x_neg;
      ef_r.yn <= y_neg;
    end
  end

  // ---------------- normalize: shift max up to bit 52 ----------------
  logic          nv_r [1:NRM];
  logic [NW-1:0] nx_r [1:NRM], ny_r [1:NRM], nm_r [1:NRM];
  flg_t          nf_r [1:NRM];

  logic          nv_in [NRM];
  logic [NW-1:0] nx_in [NRM], ny_in [NRM], nm_in [NRM];
  flg_t          nf_in [NRM];

  for (genvar k = 0; k < NRM; k++) begin : g_norm
    localparam int S = 32 >> k;
    logic sft;

    if (k == 0) begin : g_first
      assign nv_in[k] = ev_r;
      assign nx_in[k] = ex_r;
      assign ny_in[k] = ey_r;
      assign nm_in[k] = em_r;
      assign nf_in[k] = ef_r;
    end else begin : g_next
      assign nv_in[k] = nv_r[k];
      assign nx_in[k] = nx_r[k];
      assign ny_in[k] = ny_r[k];
      assign nm_in[k] = nm_r[k];
      assign nf_in[k] = nf_r[k];
    end

    assign sft = (nm_in[k][NW-1 -: S] == '0);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nv_r[k+1] <= 1'b0;
      end else if (ctl.en) begin
        nv_r[k+1] <= nv_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        nx_r[k+1] <= sft ? (nx_in[k] << S) : nx_in[k];
        ny_r[k+1] <= sft ? (ny_in[k] << S) : ny_in[k];
        nm_r[k+1] <= sft ? (nm_in[k] << S) : nm_in[k];
        nf_r[k+1] <= nf_in[k];
      end
    end
  end

  // ---------------- CORDIC vectoring ----------------
  logic                 cv_r [1:STP];
  logic signed [CW-1:0] cx_r [1:STP], cy_r [1:STP];
  logic signed [ZW-1:0] cz_r [1:STP];
  flg_t                 cf_r [1:STP];

  logic                 cv_in [STP];
  logic signed [CW-1:0] cx_in [STP], cy_in [STP];
  logic signed [ZW-1:0] cz_in [STP];
  flg_t                 cf_in [STP];

  for (genvar i = 0; i < STP; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] AT = ZW'(tah_pkg::atan_q24(i));
    logic signed [CW-1:0] dx, dy;
    logic                 pos;

    if (i == 0) begin : g_first
      assign cv_in[i] = nv_r[NRM];
      assign cx_in[i] = $signed({4'b0, nx_r[NRM]});
      assign cy_in[i] = $signed({4'b0, ny_r[NRM]});
      assign cz_in[i] = '0;
      assign cf_in[i] = nf_r[NRM];
    end else begin : g_next
      assign cv_in[i] = cv_r[i];
      assign cx_in[i] = cx_r[i];
      assign cy_in[i] = cy_r[i];
      assign cz_in[i] = cz_r[i];
      assign cf_in[i] = cf_r[i];
    end

    // floor shifts of the current vector
    assign dx  = cy_in[i] >>> i;
    assign dy  = cx_in[i] >>> i;
    assign pos = !cy_in[i][CW-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i+1] <= 1'b0;
      end else if (ctl.en) begin
        cv_r[i+1] <= cv_in[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        cx_r[i+1] <= pos ? (cx_in[i] + dx) : (cx_in[i] - dx);
        cy_r[i+1] <= pos ? (cy_in[i] - dy) : (cy_in[i] + dy);
        cz_r[i+1] <= pos ? (cz_in[i] + AT) : (cz_in[i] - AT);
        cf_r[i+1] <= cf_in[i];
      end
    end
  end

  // ---------------- clamp, axis cases, round ----------------
  logic signed [ZW-1:0] zf;
  logic [30:0]          zc;
  logic [31:0]          zr;
  logic                 pv_r;
  logic [AW-1:0]        a_r;
  logic                 pxn_r, pyn_r;

  assign zf = cz_r[STP];

  always_comb begin
    priority if (cf_r[STP].yz) begin
      zc = '0;
    end else if (cf_r[STP].xz) begin
      zc = Z90;
    end else if (zf < 0) begin
      zc = '0;
    end else if (zf > $signed({3'b0, Z90})) begin
      zc = Z90;
    end else begin
      zc = zf[30:0];
    end
  end

  assign zr = ({1'b0, zc} + HALF) >> SH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (ctl.en) begin
      pv_r <= cv_r[STP];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      a_r   <= zr[AW-1:0];
      pxn_r <= cf_r[STP].xn;
      pyn_r <= cf_r[STP].yn;
    end
  end

  // ---------------- quadrant restore ----------------
  logic signed [RW-1:0] ae, rq;
  logic                 ov_r;

  assign ae = $signed(RW'(a_r));
  assign rq = pxn_r ? ($signed(A180) - ae) : ae;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (ctl.en) begin
      ov_r <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      angle <= pyn_r ? -rq : rq;
    end
  end

  assign out_vld = ov_r;

endmodule

### src/tah_obuf.sv
// ----------------------------------------------------------------------------
// tah_obuf - two-entry result buffer
// Decouples the pipeline from the result channel; full is a registered flag.
// ----------------------------------------------------------------------------
module tah_obuf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tah_pkg::res_t  din,
  output logic           full,
  tah_out_if.source      out_ch
);

  tah_pkg::res_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          pop;

  assign pop  = out_ch.valid && out_ch.ready;
  assign full = (cnt_r == 2'd2);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  assign out_ch.valid         = (cnt_r != 2'd0);
  assign out_ch.roll_angle    = mem_r[rp_r].roll;
  assign out_ch.pitch_angle   = mem_r[rp_r].pitch;
  assign out_ch.heading_angle = mem_r[rp_r].heading;

  // one entry plus a lone push fills the buffer
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop && cnt_r == 2'd1) |=> full)
    else $error("result buffer did not fill");

endmodule

### src/tilt_and_heading_from_sensor_frame.sv
// ----------------------------------------------------------------------------
// tilt_and_heading_from_sensor_frame - roll, pitch and heading per frame
// Squares, square root, three CORDIC arctangents and an output buffer.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one raw frame per request (accel_x/y/z, mag_x/y, signed
//   16-bit counts). out_ch returns one result per frame, in order: roll
//   atan2(ay,az), pitch atan2(-ax,sqrt(ay^2+az^2)) and heading atan2(my,mx)
//   folded to 0..360, all in 2^-ANGLE_FRAC_BITS degree.
//   Throughput: one frame per cycle while the output buffer is not full. On its way
//   from acceptance to out_ch.valid a frame passes 3 input/square/sum stages, 32
//   square-root stages (one root bit each) and 37 arctangent stages (entry,
//   6 normalize, 28 CORDIC, 2 rounding/quadrant), plus the output buffer register.
//   Every stage advances on a common enable taken from the registered full
//   flag of a two-entry output buffer. When the receiver stalls, the buffer
//   fills and the pipeline freezes in place; in_ch.ready drops only then.
//   Reset (rst_n low, synchronous) clears all valid bits and the buffer;
//   in_ch.ready is low while reset is held and no item is kept across reset.
// ----------------------------------------------------------------------------
module tilt_and_heading_from_sensor_frame #(
  parameter int ANGLE_FRAC_BITS = tah_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tah_in_if.sink     in_ch,
  tah_out_if.source  out_ch
);

  localparam int SQ = tah_pkg::SQRT_STEPS;
  localparam int RW = ANGLE_FRAC_BITS + 10;

  function automatic logic [31:0] mag16(input logic signed [15:0] v);
    logic signed [16:0] e;
    e = {v[15], v};
    return 32'(unsigned'(v[15] ? -e : e));
  endfunction

  logic en;
  logic full;

  assign en          = !full;
  assign in_ch.ready = en && rst_n;

  // ---------------- input register ----------------
  logic          v0_r;
  tah_pkg::raw_t raw0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      raw0_r <= {in_ch.accel_x, in_ch.accel_y, in_ch.accel_z, in_ch.mag_x, in_ch.mag_y};
    end
  end

  // ---------------- squares ----------------
  logic signed [31:0] py, pz;
  logic               v1_r;
  logic [31:0]        sqy_r, sqz_r;
  tah_pkg::raw_t      raw1_r;

  assign py = raw0_r.ay * raw0_r.ay;
  assign pz = raw0_r.az * raw0_r.az;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqy_r  <= unsigned'(py);
      sqz_r  <= unsigned'(pz);
      raw1_r <= raw0_r;
    end
  end

  // ---------------- sum of squares ----------------
  logic          v2_r;
  logic [31:0]   sum_r;
  tah_pkg::raw_t raw2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r  <= sqy_r + sqz_r;
      raw2_r <= raw1_r;
    end
  end

  // ---------------- square root and matching frame delay ----------------
  tah_pkg::pipe_ctl_t sq_ctl;
  logic               sq_vld;
  logic [31:0]        root;

  assign sq_ctl.en  = en;
  assign sq_ctl.vld = v2_r;

  tah_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (sq_ctl),
    .s       (sum_r),
    .out_vld (sq_vld),
    .root    (root)
  );

  tah_pkg::raw_t dl_r [1:SQ];

  for (genvar i = 0; i < SQ; i++) begin : g_dly
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) dl_r[1] <= raw2_r;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) dl_r[i+1] <= dl_r[i];
      end
    end
  end

  // ---------------- three arctangents ----------------
  tah_pkg::raw_t        rd;
  tah_pkg::pipe_ctl_t   at_ctl;
  logic                 rv, pv, hv;
  logic signed [RW-1:0] ra, pa, ha;

  assign rd         = dl_r[SQ];
  assign at_ctl.en  = en;
  assign at_ctl.vld = sq_vld;

  tah_atan2 #(.FRAC(ANGLE_FRAC_BITS)) u_roll (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (at_ctl),
    .ux      (mag16(rd.az)),
    .uy      (mag16(rd.ay)),
    .x_neg   (rd.az[15]),
    .y_neg   (rd.ay[15]),
    .out_vld (rv),
    .angle   (ra)
  );

  tah_atan2 #(.FRAC(ANGLE_FRAC_BITS)) u_pitch (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (at_ctl),
    .ux      (root),
    .uy      (mag16(rd.ax) << 16),
    .x_neg   (1'b0),
    .y_neg   (!rd.ax[15] && (rd.ax != '0)),
    .out_vld (pv),
    .angle   (pa)
  );

  tah_atan2 #(.FRAC(ANGLE_FRAC_BITS)) u_head (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (at_ctl),
    .ux      (mag16(rd.mx)),
    .uy      (mag16(rd.my)),
    .x_neg   (rd.mx[15]),
    .y_neg   (rd.my[15]),
    .out_vld (hv),
    .angle   (ha)
  );

  // ---------------- heading fold and output buffer ----------------
  logic signed [31:0] r32, p32, h32, hf32;
  logic               last_vld;
  logic               push;
  tah_pkg::res_t      res;

  assign r32  = 32'(ra);
  assign p32  = 32'(pa);
  assign h32  = 32'(ha);
  assign hf32 = (h32 < 0) ? (h32 + 32'(360 * (2 ** ANGLE_FRAC_BITS))) : h32;

  assign last_vld    = rv && pv && hv;
  assign push        = en && last_vld;
  assign res.roll    = r32[15:0];
  assign res.pitch   = p32[14:0];
  assign res.heading = hf32[15:0];

  tah_obuf u_obuf (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .din    (res),
    .full   (full),
    .out_ch (out_ch)
  );

  // a frozen pipeline keeps its last-stage item
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(last_vld))
    else $error("pipeline lost an item while stalled");

  // the three units run in lockstep
  a_lock: assert property (@(posedge clk) disable iff (!rst_n)
    (rv == pv) && (pv == hv))
    else $error("arctangent units out of step");

  // heading stays below a full turn
  a_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && ANGLE_FRAC_BITS == 7) |-> (out_ch.heading_angle < 16'd46080))
    else $error("heading out of range");

  // roll and pitch stay within their half and quarter turns
  a_tilt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && ANGLE_FRAC_BITS == 7) |->
      (out_ch.roll_angle <= 16'sd23040 && out_ch.roll_angle >= -16'sd23040 &&
       out_ch.pitch_angle <= 15'sd11520 && out_ch.pitch_angle >= -15'sd11520))
    else $error("tilt out of range");

endmodule

### tb/tb_tilt_and_heading_from_sensor_frame.sv
// ----------------------------------------------------------------------------
// tb_tilt_and_heading_from_sensor_frame - self-checking bench for tilt/heading
// Drives raw sensor frames with random gaps, predicts roll, pitch and heading
// with a bit-exact CORDIC model and compares every result in order.
// ----------------------------------------------------------------------------
module tb_tilt_and_heading_from_sensor_frame;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = tah_pkg::ANGLE_FRAC_BITS_DEF;
  localparam int N_RANDOM = 1250;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tah_in_if  in_ch ();
  tah_out_if out_ch ();

  tilt_and_heading_from_sensor_frame u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  tah_pkg::raw_t frame_q[$];
  tah_pkg::res_t angle_q[$];
  int   n_err = 0;
  int   n_res = 0;
  int   n_sent = 0;
  bit   stim_done = 0;

  // floor shift of a signed value
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // first-quadrant angle in Q24 degrees
  function automatic longint quad_angle(longint unsigned ux, longint unsigned uy);
    longint x, y, z, dx, dy;
    longint unsigned m;
    int i;
    if (uy == 0) return 0;
    if (ux == 0) return longint'(90) << 24;
    m = (ux > uy) ? ux : uy;
    i = 0;
    while (i < 64 && m < (64'd1 << 52)) begin
      ux <<= 1; uy <<= 1; m <<= 1; i++;
    end
    x = longint'(ux);
    y = longint'(uy);
    z = 0;
    for (i = 0; i < tah_pkg::CORDIC_STEPS; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(tah_pkg::atan_q24(i));
      end else begin
        x -= dx; y += dy; z -= longint'(tah_pkg::atan_q24(i));
      end
    end
    if (z < 0) z = 0;
    if (z > (longint'(90) << 24)) z = longint'(90) << 24;
    return z;
  endfunction

  function automatic longint arctan2(longint y, longint x);
    longint z, a, r;
    z = quad_angle((x < 0) ? -x : x, (y < 0) ? -y : y);
    a = (z + (longint'(1) << (24 - FRAC - 1))) >>> (24 - FRAC);
    r = (x < 0) ? ((longint'(180) << FRAC) - a) : a;
    if (y < 0) r = -r;
    return r;
  endfunction

  function automatic tah_pkg::res_t tilt_heading(tah_pkg::raw_t f);
    tah_pkg::res_t o;
    longint ay, az, hz, hd;
    ay = f.ay;
    az = f.az;
    hz = root64(longint'(ay * ay + az * az) << 32);
    hd = arctan2(longint'(f.my), longint'(f.mx));
    if (hd < 0) hd += longint'(360) << FRAC;
    o.roll    = 16'(arctan2(ay, az));
    o.pitch   = 15'(arctan2(-longint'(f.ax) * 65536, hz));
    o.heading = 16'(hd);
    return o;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // random 16-bit count, weighted toward edges and small magnitudes
  function automatic logic signed [15:0] rnd_count();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'sh8000;
    if (p == 1) return 16'sh7fff;
    if (p == 2) return 16'(int'($urandom_range(0, 8)) - 4);
    return 16'($urandom);
  endfunction

  task automatic add_frame(logic signed [15:0] ax, ay, az, mx, my);
    tah_pkg::raw_t f;
    f = '{ax: ax, ay: ay, az: az, mx: mx, my: my};
    frame_q.push_back(f);
  endtask

  // stimulus
  initial begin
    add_frame(0, 0, 0, 0, 0);                              // both operands zero
    add_frame(0, 0, -100, -5, 0);                          // zero y, negative x
    add_frame(0, 300, 0, 0, 200);                          // zero x, +90
    add_frame(0, -300, 0, 0, -200);                        // zero x, -90
    add_frame(1000, 0, 0, 1, -1);                          // flat, pitch -90
    add_frame(-1000, 0, 0, 1000000 % 32768, -1);           // flat, pitch +90
    add_frame(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    add_frame(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    add_frame(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    add_frame(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    add_frame(5, 1, 16'sh7fff, 16'sh7fff, -1);             // heading a hair below zero, rounds to zero
    add_frame(-5, -1, 16'sh8000, 32000, -1);
    add_frame(1, 1, 1, -1, -1);
    add_frame(-1, -1, -1, -1, 1);
    add_frame(0, 16'sh8000, 0, 16'sh8000, 0);
    add_frame(16'sh8000, 0, 0, 0, 16'sh8000);
    add_frame(-3, 4, -3, 4, -3);
    add_frame(3, -4, 4, -3, 4);
    for (int i = 0; i < N_RANDOM; i++)
      add_frame(rnd_count(), rnd_count(), rnd_count(), rnd_count(), rnd_count());
    stim_done = 1;
  end

  // driver
  int            in_gap = 0;
  tah_pkg::raw_t cur;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.accel_x = '0; in_ch.accel_y = '0; in_ch.accel_z = '0;
    in_ch.mag_x = '0; in_ch.mag_y = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold request until accepted
    end else begin
      if (in_ch.valid) n_sent++;
      if (in_gap > 0 || frame_q.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (in_gap > 0) in_gap--;
      end else begin
        cur = frame_q.pop_front();
        angle_q.push_back(tilt_heading(cur));
        in_ch.valid   <= 1'b1;
        in_ch.accel_x <= cur.ax;
        in_ch.accel_y <= cur.ay;
        in_ch.accel_z <= cur.az;
        in_ch.mag_x   <= cur.mx;
        in_ch.mag_y   <= cur.my;
        in_gap = gap_len();
      end
    end
  end

  // monitor and receiver stalls
  int            out_gap = 0;
  tah_pkg::res_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_res++;
        if (angle_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result at %0t", $realtime);
        end else begin
          want = angle_q.pop_front();
          if (out_ch.roll_angle !== want.roll || out_ch.pitch_angle !== want.pitch ||
              out_ch.heading_angle !== want.heading) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch #%0d: roll %0d/%0d pitch %0d/%0d heading %0d/%0d (exp/act)",
                       n_res, want.roll, out_ch.roll_angle, want.pitch,
                       out_ch.pitch_angle, want.heading, out_ch.heading_angle);
          end
        end
      end
      if (out_gap > 0) begin
        out_ch.ready <= 1'b0;
        out_gap--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap = gap_len();
      end
    end
  end

  // reset, drain and verdict
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    while (frame_q.size() != 0 || in_ch.valid || angle_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d frames, checked %0d results: zero and axis cases, full-scale counts,",
             n_sent, n_res);
    $display("random tilt and heading under random gaps and receiver stalls");
    if (n_err == 0 && angle_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", n_err);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // timeout
  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
